/* sv/wps_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wps_pkg
// Types, register codes and byte helpers for the word phrase spotter.
// ----------------------------------------------------------------------------
package wps_pkg;

    localparam int NUM_WORD_REGS = 5;
    localparam int PHRASE_W      = 64;
    localparam int CFG_INDEX_W   = 3;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [7:0] LOWER_BELOW  = 8'd96;
    localparam logic [7:0] LOWER_ABOVE  = 8'd123;
    localparam logic [7:0] CASE_OFFSET  = 8'd32;
    localparam logic [7:0] PRINT_LAST   = 8'd126;
    localparam logic [7:0] SPACE_CHAR   = 8'd32;

    localparam logic [CFG_INDEX_W-1:0] CFG_PHRASE_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHRASE_WORD_A = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PHRASE_WORD_E = 3'd5;

    typedef struct packed {
        logic [7:0] ch;
        logic       delim;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [2:0]                                 phrase_length;
        logic [NUM_WORD_REGS-1:0][PHRASE_W-1:0]     phrase_words;
    } t_cfg;

    function automatic logic [7:0] fold_byte(input logic [7:0] b);
        logic [7:0] f;
        f = b;
        if (f > LOWER_BELOW && f < LOWER_ABOVE) begin
            f = f - CASE_OFFSET;
        end
        if (f < SPACE_CHAR || f > PRINT_LAST) begin
            f = SPACE_CHAR;
        end
        return f;
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        logic d;
        case (c)
            " ", "_", "-", "(", ")", "[", "]",
            "{", "}", "<", ">", ".", 8'h22: d = 1'b1;
            default:                        d = 1'b0;
        endcase
        return d;
    endfunction

    function automatic logic [7:0] phrase_byte(input logic [PHRASE_W-1:0] w,
                                               input logic [2:0] pos);
        return w[{pos, 3'b000} +: 8];
    endfunction

endpackage
`default_nettype wire

/* sv/wps_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wps_front
// Input stage: fold each byte and mark delimiters and stream end.
// ----------------------------------------------------------------------------
module wps_front import wps_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_last,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_item           o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    always_comb begin
        n_item.ch    = fold_byte(i_byte);
        n_item.delim = is_delim(n_item.ch);
        n_item.last  = i_last;
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule
`default_nettype wire

/* sv/wps_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wps_queue
// Two-entry queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module wps_queue import wps_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    output logic       o_valid,
    input  wire logic  i_ready,
    output t_item      o_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_ready = r_count < CNT_W'(QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

endmodule
`default_nettype wire

/* sv/wps_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// wps_back
// Word tracker: per-character phrase compares, match history, hit output.
// ----------------------------------------------------------------------------
module wps_back import wps_pkg::*; #(
    parameter int MAX_WORD_CHARS   = 8,
    parameter int MAX_PHRASE_WORDS = 5
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cfg        i_cfg,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_item       i_item,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_hit,
    output logic [31:0]      o_index
);

    localparam int POS_W      = $clog2(MAX_WORD_CHARS + 1);
    localparam int HIST_DEPTH = MAX_PHRASE_WORDS - 1;

    logic [POS_W-1:0]         r_pos;
    logic                     r_inside;
    logic [NUM_WORD_REGS-1:0] r_match;
    logic [NUM_WORD_REGS-1:0] r_hist [HIST_DEPTH];
    logic [31:0]              r_words;
    logic                     r_out_valid;
    logic                     r_hit;
    logic [31:0]              r_index;

    logic [POS_W-1:0]         n_pos;
    logic                     n_inside;
    logic [NUM_WORD_REGS-1:0] n_match;
    logic [NUM_WORD_REGS-1:0] n_cur;
    logic                     n_close;
    logic                     n_hit;
    logic [31:0]              n_words;
    logic                     pop;

    assign pop     = i_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_out_valid || i_ready;
    assign o_valid = r_out_valid;
    assign o_hit   = r_hit;
    assign o_index = r_index;

    always_comb begin
        logic [POS_W-1:0]         pos_w;
        logic [NUM_WORD_REGS-1:0] m_w;
        logic                     in_w;
        logic [3:0]               pos4;
        int                       len;
        logic                     ok;
        pos_w = r_pos;
        m_w   = r_match;
        in_w  = r_inside;
        if (!i_item.delim) begin
            if (!r_inside) begin
                pos_w = '0;
                m_w   = '1;
                in_w  = 1'b1;
            end
            if (int'(pos_w) < MAX_WORD_CHARS) begin
                pos4 = 4'(pos_w);
                for (int k = 0; k < NUM_WORD_REGS; k++) begin
                    if (phrase_byte(i_cfg.phrase_words[k], pos4[2:0]) != i_item.ch) begin
                        m_w[k] = 1'b0;
                    end
                end
                pos_w = pos_w + 1'b1;
            end else begin
                m_w = '0;
            end
        end
        n_close = in_w && (i_item.delim || i_item.last);
        pos4    = 4'(pos_w);
        for (int k = 0; k < NUM_WORD_REGS; k++) begin
            n_cur[k] = m_w[k] && ((int'(pos_w) >= MAX_WORD_CHARS) ||
                       (phrase_byte(i_cfg.phrase_words[k], pos4[2:0]) == 8'h00));
        end
        len = int'(i_cfg.phrase_length);
        ok  = 1'b0;
        if (len >= 2 && len <= MAX_PHRASE_WORDS && len <= NUM_WORD_REGS) begin
            ok = n_cur[3'(len - 1)];
            for (int j = 0; j < HIST_DEPTH; j++) begin
                if (j + 2 <= len) begin
                    ok = ok && r_hist[j][3'(len - 2 - j)];
                end
            end
        end
        n_hit   = n_close && ok;
        n_words = (n_close && r_words != '1) ? r_words + 32'd1 : r_words;
        if (n_close) begin
            n_inside = 1'b0;
            n_pos    = '0;
            n_match  = '1;
        end else begin
            n_inside = in_w;
            n_pos    = pos_w;
            n_match  = m_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_inside    <= 1'b0;
            r_match     <= '1;
            r_words     <= '0;
            r_out_valid <= 1'b0;
            for (int j = 0; j < HIST_DEPTH; j++) begin
                r_hist[j] <= '0;
            end
        end else begin
            if (pop) begin
                r_pos    <= n_pos;
                r_inside <= n_inside;
                r_match  <= n_match;
                r_words  <= n_words;
                if (n_close) begin
                    for (int j = HIST_DEPTH - 1; j > 0; j--) begin
                        r_hist[j] <= r_hist[j-1];
                    end
                    r_hist[0] <= n_cur;
                end
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (pop) begin
            r_hit   <= n_hit;
            r_index <= n_words;
        end
    end

endmodule
`default_nettype wire

/* sv/word_phrase_spotter.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// word_phrase_spotter
// Path: front input register, two-entry queue, then the registered tracker output.
// Throughput: one byte per cycle while the result sink is ready, set by the combinational word tracker.
// The queue lets new bytes enter while a result waits at the output.
// Reset: synchronous, active low; clears config, queue and match history.
// Configuration writes are always ready; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module word_phrase_spotter import wps_pkg::*; #(
    parameter int MAX_WORD_CHARS   = 8,
    parameter int MAX_PHRASE_WORDS = 5
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [PHRASE_W-1:0]    i_cfg_data,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [7:0]             i_s_tdata,   // [7:0] text_byte
    input  wire logic                   i_s_tlast,   // stream_end
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [31:0]                 o_m_tdata,   // [31:0] word_index
    output logic                        o_m_tuser    // [0] phrase_hit
);

    t_cfg  r_cfg;
    logic  f_valid;
    logic  f_ready;
    t_item f_item;
    logic  q_valid;
    logic  q_ready;
    t_item q_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_PHRASE_LENGTH) begin
                r_cfg.phrase_length <= i_cfg_data[2:0];
            end else if (i_cfg_index >= CFG_PHRASE_WORD_A &&
                         i_cfg_index <= CFG_PHRASE_WORD_E) begin
                r_cfg.phrase_words[i_cfg_index - CFG_PHRASE_WORD_A] <= i_cfg_data;
            end
        end
    end

    wps_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_byte  (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_item  (f_item)
    );

    wps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_item  (f_item),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_item  (q_item)
    );

    wps_back #(
        .MAX_WORD_CHARS   (MAX_WORD_CHARS),
        .MAX_PHRASE_WORDS (MAX_PHRASE_WORDS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_item  (q_item),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_hit   (o_m_tuser),
        .o_index (o_m_tdata)
    );

endmodule
`default_nettype wire

/* dv/tb_word_phrase_spotter.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_word_phrase_spotter
// Streams text bytes into the phrase spotter and checks the hit flag and the
// word count of every result against a cycle-free model of the word tracker.
// Covers directed phrases, register map corners and long random text runs
// under several source and sink throttling profiles.
// ----------------------------------------------------------------------------
module tb_word_phrase_spotter;
    import wps_pkg::*;

    localparam int MAX_WORD_CHARS   = 8;
    localparam int MAX_PHRASE_WORDS = 5;
    localparam int HIST_DEPTH       = MAX_PHRASE_WORDS - 1;
    localparam int CHUNK_BYTES      = 125;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_LO = CFG_PHRASE_WORD_E + 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_HI = '1;

    localparam logic [7:0] DELIMS [13] = '{
        " ", "_", "-", "(", ")", "[", "]", "{", "}", "<", ">", ".", 8'h22
    };

    // bit 8 is stream_end
    localparam logic [8:0] DIRECTED_TEXT [26] = '{
        9'h000, 9'h061, 9'h062, 9'h07F, 9'h063, 9'h022,
        9'h077, 9'h078, 9'h079, 9'h07A, 9'h057, 9'h058, 9'h059, 9'h05A,
        9'h12E, 9'h1FF,
        9'h077, 9'h078, 9'h079, 9'h07A, 9'h077, 9'h078, 9'h079, 9'h07A,
        9'h071, 9'h020
    };

    typedef struct packed {
        logic        hit;
        logic [31:0] word_count;
    } t_spot;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index = '0;
    logic [PHRASE_W-1:0]    i_cfg_data  = '0;
    logic                   i_s_tvalid  = 1'b0;
    logic                   o_s_tready;
    logic [7:0]             i_s_tdata   = '0;  // [7:0] text_byte
    logic                   i_s_tlast   = 1'b0;  // stream_end
    logic                   o_m_tvalid;
    logic                   i_m_tready  = 1'b0;
    logic [31:0]            o_m_tdata;  // [31:0] word_index
    logic                   o_m_tuser;  // [0] phrase_hit

    int n_fail         = 0;
    int n_sent         = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;

    t_spot       spot_q [$];
    t_spot       got_res;
    t_spot       want_res;
    logic [7:0]  run_q [$];
    logic [63:0] stim_words [NUM_WORD_REGS];
    logic [2:0]  stim_len = '0;

    logic [2:0]               pw_len;
    logic [63:0]              pw_words [NUM_WORD_REGS];
    logic [3:0]               wd_pos;
    logic                     wd_open;
    logic [NUM_WORD_REGS-1:0] wd_match;
    logic [NUM_WORD_REGS-1:0] word_hist [HIST_DEPTH];
    logic [31:0]              word_count;

    word_phrase_spotter #(
        .MAX_WORD_CHARS   (MAX_WORD_CHARS),
        .MAX_PHRASE_WORDS (MAX_PHRASE_WORDS)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    function automatic t_spot track_word(input logic [7:0] raw, input logic last);
        logic [7:0]               c;
        logic                     dl;
        logic                     ok;
        logic                     ends;
        logic [NUM_WORD_REGS-1:0] cur;
        t_spot                    r;
        c  = raw;
        dl = 1'b0;
        r.hit = 1'b0;
        if (c > LOWER_BELOW && c < LOWER_ABOVE) begin
            c = c - CASE_OFFSET;
        end
        if (c < SPACE_CHAR || c > PRINT_LAST) begin
            c = SPACE_CHAR;
        end
        for (int i = 0; i < 13; i++) begin
            if (DELIMS[i] == c) dl = 1'b1;
        end
        if (!dl) begin
            if (!wd_open) begin
                wd_pos   = '0;
                wd_match = '1;
                wd_open  = 1'b1;
            end
            if (wd_pos < MAX_WORD_CHARS) begin
                for (int k = 0; k < NUM_WORD_REGS; k++) begin
                    if (pw_words[k][8*wd_pos +: 8] != c) wd_match[k] = 1'b0;
                end
                wd_pos = wd_pos + 4'd1;
            end else begin
                wd_match = '0;
            end
        end
        if (wd_open && (dl || last)) begin
            cur = '0;
            for (int k = 0; k < NUM_WORD_REGS; k++) begin
                ends = (wd_pos >= MAX_WORD_CHARS) ? 1'b1 :
                       (pw_words[k][8*wd_pos +: 8] == 8'h00);
                if (ends && wd_match[k]) cur[k] = 1'b1;
            end
            if (pw_len >= 2 && pw_len <= MAX_PHRASE_WORDS && pw_len <= NUM_WORD_REGS) begin
                ok = cur[pw_len-1];
                for (int j = 0; j + 2 <= pw_len; j++) begin
                    if (!word_hist[j][pw_len-2-j]) ok = 1'b0;
                end
                r.hit = ok;
            end
            for (int j = HIST_DEPTH - 1; j > 0; j--) begin
                word_hist[j] = word_hist[j-1];
            end
            word_hist[0] = cur;
            if (word_count != '1) word_count = word_count + 32'd1;
            wd_open  = 1'b0;
            wd_pos   = '0;
            wd_match = '1;
        end
        r.word_count = word_count;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pw_len     = '0;
            wd_pos     = '0;
            wd_open    = 1'b0;
            wd_match   = '1;
            word_count = '0;
            for (int k = 0; k < NUM_WORD_REGS; k++) pw_words[k] = '0;
            for (int j = 0; j < HIST_DEPTH; j++) word_hist[j] = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_PHRASE_LENGTH) begin
                    pw_len = i_cfg_data[2:0];
                end else if (i_cfg_index >= CFG_PHRASE_WORD_A &&
                             i_cfg_index <= CFG_PHRASE_WORD_E) begin
                    pw_words[i_cfg_index - CFG_PHRASE_WORD_A] = i_cfg_data;
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                spot_q.push_back(track_word(i_s_tdata, i_s_tlast));
            end
            if (o_m_tvalid && i_m_tready) begin
                got_res.hit        = o_m_tuser;
                got_res.word_count = o_m_tdata;
                if (spot_q.size() == 0) begin
                    $error("result with no request pending: word_index %0d", o_m_tdata);
                    n_fail++;
                end else begin
                    want_res = spot_q.pop_front();
                    if (got_res.hit !== want_res.hit) begin
                        $error("phrase_hit: expected %0d, actual %0d",
                               want_res.hit, got_res.hit);
                        n_fail++;
                    end
                    if (got_res.word_count !== want_res.word_count) begin
                        $error("word_index: expected %0d, actual %0d",
                               want_res.word_count, got_res.word_count);
                        n_fail++;
                    end
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        n_sent++;
    endtask

    // let the checker log the last request before looking at the queue
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (spot_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_phrase(input logic [63:0] len_val);
        logic [CFG_INDEX_W-1:0] idx;
        for (int k = 0; k < NUM_WORD_REGS; k++) begin
            idx = CFG_PHRASE_WORD_A + k[CFG_INDEX_W-1:0];
            cfg_write(idx, stim_words[k]);
        end
        cfg_write(CFG_PHRASE_LENGTH, len_val);
        stim_len = len_val[2:0];
    endtask

    task automatic push_word_text(input logic [63:0] w);
        logic [7:0] b;
        logic       done;
        done = 1'b0;
        for (int i = 0; i < MAX_WORD_CHARS; i++) begin
            b = w[8*i +: 8];
            if (b == 8'h00) done = 1'b1;
            if (!done) begin
                if (b >= "A" && b <= "Z" && $urandom_range(0, 1) == 1) b = b + CASE_OFFSET;
                run_q.push_back(b);
            end
        end
    endtask

    task automatic send_gap();
        logic [7:0] b;
        int         n;
        n = $urandom_range(1, 2);
        repeat (n) begin
            case ($urandom_range(0, 3))
                0:       b = 8'($urandom_range(0, 31));
                1:       b = 8'($urandom_range(127, 255));
                default: b = DELIMS[$urandom_range(0, 12)];
            endcase
            send_byte(b, $urandom_range(0, 19) == 0);
        end
    endtask

    // close with stream_end now and then instead of a delimiter
    task automatic finish_word();
        logic end_here;
        end_here = ($urandom_range(0, 9) == 0);
        while (run_q.size() != 0) begin
            send_byte(run_q.pop_front(), end_here && run_q.size() == 0);
        end
        if (!end_here) send_gap();
    endtask

    task automatic send_random_word();
        int n;
        int k;
        k = $urandom_range(0, NUM_WORD_REGS - 1);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                n = (stim_len >= 1 && stim_len <= NUM_WORD_REGS) ? stim_len :
                    $urandom_range(1, NUM_WORD_REGS);
                for (int i = 0; i < n; i++) begin
                    push_word_text(stim_words[i]);
                    finish_word();
                end
            end
            4, 5: begin
                n = $urandom_range(1, MAX_WORD_CHARS);
                repeat (n) run_q.push_back(8'("A" + $urandom_range(0, 3)));
                finish_word();
            end
            6: begin
                push_word_text(stim_words[k]);
                n = $urandom_range(MAX_WORD_CHARS + 1, MAX_WORD_CHARS + 4);
                while (run_q.size() < n) run_q.push_back(8'("A" + $urandom_range(0, 3)));
                finish_word();
            end
            7: begin
                push_word_text(stim_words[k]);
                if (run_q.size() != 0 && $urandom_range(0, 1) == 1) begin
                    run_q[$urandom_range(0, run_q.size() - 1)] =
                        8'("A" + $urandom_range(0, 3));
                end else begin
                    run_q.push_back(8'("A" + $urandom_range(0, 3)));
                end
                finish_word();
            end
            8: begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 4) == 0);
            end
            default: send_gap();
        endcase
    endtask

    function automatic logic [63:0] rand_phrase_word();
        logic [63:0] w;
        int          n;
        w = '0;
        case ($urandom_range(0, 19))
            0: w = '0;
            1: w = '1;
            2: w = {$urandom, $urandom};
            default: begin
                n = $urandom_range(1, MAX_WORD_CHARS);
                for (int i = 0; i < n; i++) w[8*i +: 8] = 8'("A" + $urandom_range(0, 3));
            end
        endcase
        return w;
    endfunction

    task automatic randomize_phrase();
        logic [2:0]  len;
        logic [63:0] len_val;
        case ($urandom_range(0, 9))
            0:       len = 3'd0;
            1:       len = 3'd1;
            2:       len = 3'($urandom_range(6, 7));
            default: len = 3'($urandom_range(2, MAX_PHRASE_WORDS));
        endcase
        for (int k = 0; k < NUM_WORD_REGS; k++) stim_words[k] = rand_phrase_word();
        if ($urandom_range(0, 3) == 0) begin
            cfg_write($urandom_range(0, 1) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
                      {$urandom, $urandom});
        end
        len_val      = {$urandom, $urandom};
        len_val[2:0] = len;
        write_phrase(len_val);
    endtask

    task automatic test_reset_state();
        send_byte("A", 1'b0);
        send_byte(" ", 1'b0);
        send_byte("z", 1'b1);
        wait_idle();
    endtask

    // AB, C, WXYZWXYZ as a three-word phrase; lower-case fourth word never matches
    task automatic test_directed_words();
        stim_words[0] = 64'h4241;
        stim_words[1] = 64'h43;
        stim_words[2] = 64'h5A59_5857_5A59_5857;
        stim_words[3] = 64'h6261;
        stim_words[4] = '0;
        write_phrase(64'd3);
        for (int i = 0; i < 26; i++) begin
            send_byte(DIRECTED_TEXT[i][7:0], DIRECTED_TEXT[i][8]);
        end
        wait_idle();
    endtask

    task automatic test_register_map();
        src_idle_pct   = 18;
        sink_stall_pct = 18;
        stim_words[0] = 64'h4241;
        stim_words[1] = 64'h4443;
        stim_words[2] = 64'h41;
        stim_words[3] = 64'h42;
        stim_words[4] = 64'h43;
        write_phrase({61'h1FFF_FFFF_FFFF_FFFF, 3'd7});
        for (int i = 0; i < NUM_WORD_REGS; i++) begin
            push_word_text(stim_words[i]);
            finish_word();
        end
        wait_idle();
        cfg_write(CFG_UNUSED_LO, '1);
        cfg_write(CFG_UNUSED_HI, '1);
        cfg_write(CFG_PHRASE_LENGTH, {61'h1FFF_FFFF_FFFF_FFFF, 3'd5});
        stim_len = 3'd5;
        for (int i = 0; i < NUM_WORD_REGS; i++) begin
            push_word_text(stim_words[i]);
            finish_word();
        end
        wait_idle();
        cfg_write(CFG_PHRASE_LENGTH, 64'd1);
        stim_len = 3'd1;
        push_word_text(stim_words[0]);
        finish_word();
        wait_idle();
    endtask

    task automatic test_random_text();
        int start;
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 64; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 64; end
                default: begin src_idle_pct = 18; sink_stall_pct = 18; end
            endcase
            for (int sub = 0; sub < 3; sub++) begin
                wait_idle();
                randomize_phrase();
                start = n_sent;
                while (n_sent - start < CHUNK_BYTES) send_random_word();
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_state();
        test_directed_words();
        test_register_map();
        test_random_text();
        wait_idle();
        repeat (8) @(posedge i_clk);
        if (spot_q.size() != 0) begin
            $error("%0d expected results never arrived", spot_q.size());
            n_fail++;
        end
        if (n_fail == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
